FILE: rtl/two_link_arm_angle_solver_core_macros.svh
// assertion macros used by the checker file
`ifndef TWO_LINK_ARM_ANGLE_SOLVER_CORE_MACROS_SVH
`define TWO_LINK_ARM_ANGLE_SOLVER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define TLAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define TLAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tlas_pkg.sv
package tlas_pkg;

  // field widths
  localparam int COORD_W   = 12;
  localparam int LINK_W    = 12;
  localparam int FRAC_BITS = 7;
  localparam int SQ_W      = 24;            // squares of coords and links
  localparam int N_W       = 26;            // signed cosine numerator
  localparam int ROOT_W    = 25;            // integer square root
  localparam int RAD_W     = 2 * ROOT_W;    // radicand
  localparam int UV_W      = ROOT_W;        // atan operands
  localparam int XY_W      = 34;            // cordic x / y
  localparam int Z_W       = 48;            // cordic angle, 1e-12 degree
  localparam int ANG_W     = 15;            // first-quadrant angle, output scale
  localparam int SHIFT_W   = 5;
  localparam int NORM_TOP  = 29;            // normalized max lies in [2^29, 2^30)
  localparam int NORM_W    = NORM_TOP + 1;

  // scaling of the cordic angle to 1/128 degree
  localparam int NUM_W     = Z_W + FRAC_BITS;
  localparam int NQ_LO     = 12;            // 1e12 = 2^12 * 244140625
  localparam int NQ_W      = NUM_W - NQ_LO;
  localparam int NHI_LO    = 22;
  localparam int NHI_W     = 32;
  localparam int RECIP_W   = 19;
  localparam int PROD_W    = NHI_W + RECIP_W;
  localparam int QE_LO     = 36;
  localparam int DIV_W     = 28;

  localparam logic [Z_W-1:0]     PICO_90   = 48'd90000000000000;
  localparam logic [NUM_W-1:0]   HALF_PICO = 55'd500000000000;
  localparam logic [DIV_W-1:0]   DIV_D     = 28'd244140625;
  localparam logic [RECIP_W-1:0] RECIP     = 19'd288230;

  // 180 degrees in output scale
  localparam int HALF_TURN = 180 * (2 ** FRAC_BITS);
  localparam int ERR_ANGLE = -(2 ** FRAC_BITS);

  typedef enum logic [0:0] {
    REG_LINK1 = 1'b0,
    REG_LINK2 = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_LINK = 2'd1,
    STATUS_UNREACH   = 2'd2
  } status_t;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero_link;
    logic origin;
    logic na_neg;
    logic nb_neg;
    logic unreach;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [UV_W-1:0]     an_a;
    logic [UV_W-1:0]     an_b;
    logic [COORD_W-1:0]  ax;
    logic [COORD_W-1:0]  ay;
  } mid_t;

  // atan(2^-i) in 1e-12 degree
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [Z_W-1:0] t;
    case (idx)
      5'd0:  t = 48'sd45000000000000;
      5'd1:  t = 48'sd26565051177078;
      5'd2:  t = 48'sd14036243467926;
      5'd3:  t = 48'sd7125016348902;
      5'd4:  t = 48'sd3576334374997;
      5'd5:  t = 48'sd1789910608246;
      5'd6:  t = 48'sd895173710211;
      5'd7:  t = 48'sd447614170861;
      5'd8:  t = 48'sd223810500369;
      5'd9:  t = 48'sd111905677066;
      5'd10: t = 48'sd55952891894;
      5'd11: t = 48'sd27976452617;
      5'd12: t = 48'sd13988227142;
      5'd13: t = 48'sd6994113675;
      5'd14: t = 48'sd3497056851;
      5'd15: t = 48'sd1748528427;
      5'd16: t = 48'sd874264214;
      5'd17: t = 48'sd437132107;
      5'd18: t = 48'sd218566053;
      5'd19: t = 48'sd109283027;
      5'd20: t = 48'sd54641513;
      5'd21: t = 48'sd27320757;
      5'd22: t = 48'sd13660378;
      5'd23: t = 48'sd6830189;
      5'd24: t = 48'sd3415095;
      5'd25: t = 48'sd1707547;
      5'd26: t = 48'sd853774;
      5'd27: t = 48'sd426887;
      5'd28: t = 48'sd213443;
      5'd29: t = 48'sd106722;
      5'd30: t = 48'sd53361;
      5'd31: t = 48'sd26680;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/tlas_isqrt.sv
// pipelined floor square root, one result bit per stage
module tlas_isqrt (
  input  logic                              clk,
  input  logic                              en,
  input  logic [tlas_pkg::RAD_W-1:0]        rad,
  output logic [tlas_pkg::ROOT_W-1:0]       root
);

  localparam int ROOT_W = tlas_pkg::ROOT_W;
  localparam int RAD_W  = tlas_pkg::RAD_W;
  localparam int TW     = RAD_W + 2;

  logic [RAD_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
    localparam int B = ROOT_W - 1 - k;
    logic [RAD_W-1:0]  rem_prev;
    logic [ROOT_W-1:0] root_prev;
    logic [TW-1:0]     trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign rem_prev  = rad;
      assign root_prev = '0;
    end else begin : g_next
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
    end

    // (r + 2^b)^2 - r^2 against the remaining radicand
    assign trial = (TW'(root_prev) << (B + 1)) | (TW'(1) << (2 * B));
    assign fits  = (trial <= TW'(rem_prev));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= fits ? RAD_W'(TW'(rem_prev) - trial) : rem_prev;
        root_r[k] <= fits ? (root_prev | (ROOT_W'(1) << B)) : root_prev;
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

FILE: rtl/tlas_atan.sv
// pipelined first-quadrant atan2(v, u) in 1/128 degree
module tlas_atan #(
  parameter int ITERATIONS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tlas_pkg::UV_W-1:0]     u_in,
  input  logic [tlas_pkg::UV_W-1:0]     v_in,
  output logic [tlas_pkg::ANG_W-1:0]    ang_out
);

  localparam int UV_W    = tlas_pkg::UV_W;
  localparam int XY_W    = tlas_pkg::XY_W;
  localparam int Z_W     = tlas_pkg::Z_W;
  localparam int SHIFT_W = tlas_pkg::SHIFT_W;
  localparam int NORM_W  = tlas_pkg::NORM_W;
  localparam int NUM_W   = tlas_pkg::NUM_W;
  localparam int NQ_W    = tlas_pkg::NQ_W;
  localparam int ANG_W   = tlas_pkg::ANG_W;
  localparam int ITER    = (ITERATIONS > 32) ? 32 : ITERATIONS;

  // leading-one position of the larger operand
  logic [UV_W-1:0]    m_c;
  logic [SHIFT_W-1:0] msb_c;

  always_comb begin
    m_c   = (u_in > v_in) ? u_in : v_in;
    msb_c = '0;
    for (int b = 0; b < UV_W; b++) begin
      if (m_c[b]) msb_c = SHIFT_W'(b);
    end
  end

  logic [SHIFT_W-1:0] sh_r;
  logic [UV_W-1:0]    u_r;
  logic [UV_W-1:0]    v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r <= SHIFT_W'(tlas_pkg::NORM_TOP) - msb_c;
      u_r  <= u_in;
      v_r  <= v_in;
    end
  end

  // normalize and run the vectoring steps
  logic signed [XY_W-1:0] cx_r [ITER+1];
  logic signed [XY_W-1:0] cy_r [ITER+1];
  logic signed [Z_W-1:0]  cz_r [1:ITER];

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= $signed(XY_W'(NORM_W'(u_r) << sh_r));
      cy_r[0] <= $signed(XY_W'(NORM_W'(v_r) << sh_r));
    end
  end

  for (genvar k = 0; k < ITER; k++) begin : g_step
    logic signed [Z_W-1:0]  z_prev;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  t;

    if (k == 0) begin : g_first
      assign z_prev = '0;
    end else begin : g_next
      assign z_prev = cz_r[k];
    end

    assign dx = cy_r[k] >>> k;
    assign dy = cx_r[k] >>> k;
    assign t  = tlas_pkg::atan_entry(5'(k));

    always_ff @(posedge clk) begin
      if (en) begin
        if (cy_r[k] > 0) begin
          cx_r[k+1] <= cx_r[k] + dx;
          cy_r[k+1] <= cy_r[k] - dy;
          cz_r[k+1] <= z_prev + t;
        end else begin
          cx_r[k+1] <= cx_r[k] - dx;
          cy_r[k+1] <= cy_r[k] + dy;
          cz_r[k+1] <= z_prev - t;
        end
      end
    end
  end

  // clamp to [0, 90] degrees and add half an output lsb
  logic [Z_W-1:0]   zc_c;
  logic [NUM_W-1:0] num_c;

  always_comb begin
    if (cz_r[ITER] < 0) begin
      zc_c = '0;
    end else if (cz_r[ITER] > $signed(tlas_pkg::PICO_90)) begin
      zc_c = tlas_pkg::PICO_90;
    end else begin
      zc_c = cz_r[ITER];
    end
    num_c = {zc_c, tlas_pkg::FRAC_BITS'(0)} + tlas_pkg::HALF_PICO;
  end

  // divide by 1e12: reciprocal estimate, then one correction step
  logic [NQ_W-1:0]              nq0_r;
  logic [NQ_W-1:0]              nq1_r;
  logic [NQ_W-1:0]              nq2_r;
  logic [tlas_pkg::NHI_W-1:0]   nhi_r;
  logic [tlas_pkg::PROD_W-1:0]  prod_r;
  logic [ANG_W-1:0]             qe_r;
  logic [NQ_W-1:0]              qd_r;
  logic [ANG_W-1:0]             q_r;
  logic [NQ_W-1:0]              rem_c;

  assign rem_c = nq2_r - qd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nq0_r  <= num_c[tlas_pkg::NQ_LO +: NQ_W];
      nhi_r  <= num_c[tlas_pkg::NHI_LO +: tlas_pkg::NHI_W];
      nq1_r  <= nq0_r;
      prod_r <= nhi_r * tlas_pkg::RECIP;
      nq2_r  <= nq1_r;
      qe_r   <= prod_r[tlas_pkg::QE_LO +: ANG_W];
      qd_r   <= prod_r[tlas_pkg::QE_LO +: ANG_W] * tlas_pkg::DIV_D;
      q_r    <= qe_r + ANG_W'(rem_c >= NQ_W'(tlas_pkg::DIV_D));
    end
  end

  assign ang_out = q_r;

endmodule

FILE: rtl/two_link_arm_angle_solver_core.sv
// Two-link planar arm angle solver.
// Input stream: one beat per target point (x, y); in_tdata holds target_x
// in bits 11:0 and target_y in bits 23:12, both two's complement.
// Output stream: one beat per target with the triangle angles, the two joint
// angles (all in 1/128 degree) in out_tdata and the status code in out_tuser.
// Link lengths are written on the cfg port (index 0 first link, 1 second);
// write them only while no beat is in flight.
// The pipeline has four setup stages for squares and products, 25 stages of
// bit-serial square root, the CORDIC units with normalization and a
// four-stage scaling divide, then the output register. Throughput is one
// beat per cycle while the receiver does not stall.
// The pipeline advances whenever the output register is empty or taken; a
// stalled receiver freezes every stage and drops in_tready, and nothing is
// lost. Reset empties the pipeline and sets both link lengths to 1.
module two_link_arm_angle_solver_core #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // target_x, target_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // tri_alpha, tri_beta, tri_gamma, joint_a, joint_b
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [11:0] cfg_wdata
);

  localparam int COORD_W  = tlas_pkg::COORD_W;
  localparam int LINK_W   = tlas_pkg::LINK_W;
  localparam int SQ_W     = tlas_pkg::SQ_W;
  localparam int N_W      = tlas_pkg::N_W;
  localparam int UV_W     = tlas_pkg::UV_W;
  localparam int RAD_W    = tlas_pkg::RAD_W;
  localparam int ROOT_W   = tlas_pkg::ROOT_W;
  localparam int ANG_W    = tlas_pkg::ANG_W;
  localparam int ITER     = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
  localparam int ATAN_LAT = ITER + 6;
  localparam int DEPTH    = 4 + ROOT_W + ATAN_LAT + 1;
  localparam int EXT_W    = 19;

  // link length registers
  logic [LINK_W-1:0] link1_r;
  logic [LINK_W-1:0] link2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link1_r <= LINK_W'(1);
      link2_r <= LINK_W'(1);
    end else if (cfg_wr_en) begin
      case (tlas_pkg::cfg_reg_t'(cfg_index))
        tlas_pkg::REG_LINK1: link1_r <= cfg_wdata;
        tlas_pkg::REG_LINK2: link2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance and valid chain
  logic             en;
  logic [DEPTH-1:0] vld_r;

  assign en        = !vld_r[DEPTH-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  // stage 1: squares, magnitudes, special cases
  logic signed [COORD_W-1:0] x_c;
  logic signed [COORD_W-1:0] y_c;
  logic [SQ_W-1:0]           s1_xx_r;
  logic [SQ_W-1:0]           s1_yy_r;
  logic [SQ_W-1:0]           s1_l1sq_r;
  logic [SQ_W-1:0]           s1_l2sq_r;
  logic [COORD_W-1:0]        s1_ax_r;
  logic [COORD_W-1:0]        s1_ay_r;
  tlas_pkg::side_t           s1_side_r;

  assign x_c = $signed(in_tdata[COORD_W-1:0]);
  assign y_c = $signed(in_tdata[2*COORD_W-1:COORD_W]);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_xx_r   <= SQ_W'(x_c * x_c);
      s1_yy_r   <= SQ_W'(y_c * y_c);
      s1_l1sq_r <= link1_r * link1_r;
      s1_l2sq_r <= link2_r * link2_r;
      s1_ax_r   <= x_c[COORD_W-1] ? COORD_W'(-x_c) : COORD_W'(x_c);
      s1_ay_r   <= y_c[COORD_W-1] ? COORD_W'(-y_c) : COORD_W'(y_c);
      s1_side_r <= '{xneg: x_c[COORD_W-1], yneg: y_c[COORD_W-1],
                     zero_link: (link1_r == '0) || (link2_r == '0),
                     origin: (x_c == '0) && (y_c == '0),
                     na_neg: 1'b0, nb_neg: 1'b0, unreach: 1'b0};
    end
  end

  // stage 2: squared distance and cosine numerators
  logic [SQ_W-1:0]        dsq_c;
  logic signed [N_W-1:0]  s2_na_r;
  logic signed [N_W-1:0]  s2_nb_r;
  logic [SQ_W-1:0]        s2_dsq_r;
  logic [SQ_W-1:0]        s2_l1sq_r;
  logic [SQ_W-1:0]        s2_l2sq_r;
  logic [COORD_W-1:0]     s2_ax_r;
  logic [COORD_W-1:0]     s2_ay_r;
  tlas_pkg::side_t        s2_side_r;

  assign dsq_c = s1_xx_r + s1_yy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_na_r   <= $signed({2'b00, s1_l2sq_r}) + $signed({2'b00, dsq_c})
                   - $signed({2'b00, s1_l1sq_r});
      s2_nb_r   <= $signed({2'b00, s1_l1sq_r}) + $signed({2'b00, dsq_c})
                   - $signed({2'b00, s1_l2sq_r});
      s2_dsq_r  <= dsq_c;
      s2_l1sq_r <= s1_l1sq_r;
      s2_l2sq_r <= s1_l2sq_r;
      s2_ax_r   <= s1_ax_r;
      s2_ay_r   <= s1_ay_r;
      s2_side_r <= s1_side_r;
    end
  end

  // stage 3: limits 4*L^2*d^2 and squared numerators
  logic [UV_W-1:0]      an_a_c;
  logic [UV_W-1:0]      an_b_c;
  logic [2*SQ_W-1:0]    pa_c;
  logic [2*SQ_W-1:0]    pb_c;
  logic [RAD_W-1:0]     s3_lim_a_r;
  logic [RAD_W-1:0]     s3_lim_b_r;
  logic [RAD_W-1:0]     s3_sq_a_r;
  logic [RAD_W-1:0]     s3_sq_b_r;
  tlas_pkg::mid_t       s3_mid_r;

  assign an_a_c = s2_na_r[N_W-1] ? UV_W'(-s2_na_r) : UV_W'(s2_na_r);
  assign an_b_c = s2_nb_r[N_W-1] ? UV_W'(-s2_nb_r) : UV_W'(s2_nb_r);
  assign pa_c   = s2_l2sq_r * s2_dsq_r;
  assign pb_c   = s2_l1sq_r * s2_dsq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_lim_a_r <= RAD_W'({pa_c, 2'b00});
      s3_lim_b_r <= RAD_W'({pb_c, 2'b00});
      s3_sq_a_r  <= an_a_c * an_a_c;
      s3_sq_b_r  <= an_b_c * an_b_c;
      s3_mid_r   <= '{side: '{xneg: s2_side_r.xneg, yneg: s2_side_r.yneg,
                              zero_link: s2_side_r.zero_link,
                              origin: s2_side_r.origin,
                              na_neg: s2_na_r[N_W-1], nb_neg: s2_nb_r[N_W-1],
                              unreach: 1'b0},
                      an_a: an_a_c, an_b: an_b_c, ax: s2_ax_r, ay: s2_ay_r};
    end
  end

  // stage 4: radicands and reachability
  logic [RAD_W:0]   diff_a_c;
  logic [RAD_W:0]   diff_b_c;
  logic [RAD_W-1:0] s4_rad_a_r;
  logic [RAD_W-1:0] s4_rad_b_r;
  tlas_pkg::mid_t   s4_mid_r;
  tlas_pkg::mid_t   mid4_c;

  assign diff_a_c = {1'b0, s3_lim_a_r} - {1'b0, s3_sq_a_r};
  assign diff_b_c = {1'b0, s3_lim_b_r} - {1'b0, s3_sq_b_r};

  always_comb begin
    mid4_c = s3_mid_r;
    mid4_c.side.unreach = diff_a_c[RAD_W] || diff_b_c[RAD_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_rad_a_r <= diff_a_c[RAD_W] ? '0 : diff_a_c[RAD_W-1:0];
      s4_rad_b_r <= diff_b_c[RAD_W] ? '0 : diff_b_c[RAD_W-1:0];
      s4_mid_r   <= mid4_c;
    end
  end

  // square roots
  logic [ROOT_W-1:0] root_a;
  logic [ROOT_W-1:0] root_b;

  tlas_isqrt u_isqrt_a (
    .clk  (clk),
    .en   (en),
    .rad  (s4_rad_a_r),
    .root (root_a)
  );

  tlas_isqrt u_isqrt_b (
    .clk  (clk),
    .en   (en),
    .rad  (s4_rad_b_r),
    .root (root_b)
  );

  // side data alongside the square roots
  tlas_pkg::mid_t d1_r [ROOT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0] <= s4_mid_r;
      for (int i = 1; i < ROOT_W; i++) begin
        d1_r[i] <= d1_r[i-1];
      end
    end
  end

  // angle units
  logic [ANG_W-1:0] q_a;
  logic [ANG_W-1:0] q_b;
  logic [ANG_W-1:0] q_xy;

  tlas_atan #(.ITERATIONS(ITER)) u_atan_a (
    .clk     (clk),
    .en      (en),
    .u_in    (d1_r[ROOT_W-1].an_a),
    .v_in    (root_a),
    .ang_out (q_a)
  );

  tlas_atan #(.ITERATIONS(ITER)) u_atan_b (
    .clk     (clk),
    .en      (en),
    .u_in    (d1_r[ROOT_W-1].an_b),
    .v_in    (root_b),
    .ang_out (q_b)
  );

  tlas_atan #(.ITERATIONS(ITER)) u_atan_xy (
    .clk     (clk),
    .en      (en),
    .u_in    (UV_W'(d1_r[ROOT_W-1].ax)),
    .v_in    (UV_W'(d1_r[ROOT_W-1].ay)),
    .ang_out (q_xy)
  );

  // flags alongside the angle units
  tlas_pkg::side_t d2_r [ATAN_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      d2_r[0] <= d1_r[ROOT_W-1].side;
      for (int i = 1; i < ATAN_LAT; i++) begin
        d2_r[i] <= d2_r[i-1];
      end
    end
  end

  // quadrant fix-up and result assembly
  tlas_pkg::side_t          sd_c;
  logic signed [EXT_W-1:0]  half_c;
  logic signed [EXT_W-1:0]  a_c;
  logic signed [EXT_W-1:0]  b_c;
  logic signed [EXT_W-1:0]  t_c;
  logic signed [EXT_W-1:0]  tq_c;
  logic signed [EXT_W-1:0]  gamma_c;
  logic signed [EXT_W-1:0]  ja_c;
  logic signed [EXT_W-1:0]  jb_c;
  tlas_pkg::status_t        status_c;
  logic [79:0]              data_c;

  always_comb begin
    sd_c    = d2_r[ATAN_LAT-1];
    half_c  = EXT_W'(tlas_pkg::HALF_TURN);
    a_c     = $signed({4'b0000, q_a});
    b_c     = $signed({4'b0000, q_b});
    tq_c    = $signed({4'b0000, q_xy});
    if (sd_c.na_neg) a_c = half_c - a_c;
    if (sd_c.nb_neg) b_c = half_c - b_c;
    t_c     = sd_c.xneg ? (half_c - tq_c) : tq_c;
    if (sd_c.yneg) t_c = -t_c;
    gamma_c = half_c - a_c - b_c;
    ja_c    = a_c - t_c;
    jb_c    = half_c - b_c;

    if (sd_c.zero_link) begin
      status_c = tlas_pkg::STATUS_ZERO_LINK;
    end else if (sd_c.origin || sd_c.unreach) begin
      status_c = tlas_pkg::STATUS_UNREACH;
    end else begin
      status_c = tlas_pkg::STATUS_OK;
    end

    if (status_c == tlas_pkg::STATUS_OK) begin
      data_c = {jb_c[14:0], ja_c[16:0], gamma_c[15:0], b_c[15:0], a_c[15:0]};
    end else begin
      data_c = {15'd0, 17'd0, 16'(tlas_pkg::ERR_ANGLE), 16'(tlas_pkg::ERR_ANGLE),
                16'(tlas_pkg::ERR_ANGLE)};
    end
  end

  // output register
  logic [79:0] out_data_r;
  logic [1:0]  out_user_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= data_c;
      out_user_r <= status_c;
    end
  end

  assign out_tvalid = vld_r[DEPTH-1];
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: rtl/tlas_checker.sv
`include "two_link_arm_angle_solver_core_macros.svh"

// port-level checks on the solver
module tlas_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // error beats carry -1 degree triangle angles and zero joint angles
  `TLAS_ASSERT_SAME(a_err_fill, out_tvalid && (out_tuser != tlas_pkg::STATUS_OK), (out_tdata[15:0] == 16'(tlas_pkg::ERR_ANGLE)) && (out_tdata[79:48] == 32'd0), "error beat fields wrong")

  // solved beats: elbow angle and beta add up to a half turn
  `TLAS_ASSERT_SAME(a_elbow_sum, out_tvalid && (out_tuser == tlas_pkg::STATUS_OK), (17'(out_tdata[79:65]) + 17'(out_tdata[31:16])) == 17'(tlas_pkg::HALF_TURN), "elbow angle inconsistent")

  // a stalled beat holds
  `TLAS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled beat changed")

  // input side only backs up behind a stalled result
  `TLAS_ASSERT_SAME(a_in_ready, 1'b1, in_tready == (!out_tvalid || out_tready), "in_tready wrong")

endmodule

bind two_link_arm_angle_solver_core tlas_checker u_tlas_checker (.*);

FILE: tb/two_link_arm_angle_solver_core_tb.sv
`timescale 1ns / 1ps

module two_link_arm_angle_solver_core_tb;

  localparam int ITERS      = 16;
  localparam int DRAIN_WAIT = 60;     // a little over the pipeline latency
  localparam int STALL_MAX  = 2000;   // cycles with no beat on either side
  localparam longint PICO   = 64'd1000000000000;
  localparam longint HALF   = 180 * 128;

  // ordered to match {out_tdata, out_tuser}
  typedef struct packed {
    logic [14:0] jb;
    logic [16:0] ja;
    logic [15:0] gamma;
    logic [15:0] beta;
    logic [15:0] alpha;
    logic [1:0]  status;
  } angles_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [11:0] cfg_wdata = '0;

  two_link_arm_angle_solver_core dut (.*);

  always #1 clk = ~clk;

  // predictor copies of the link registers
  longint unsigned link1_q = 1, link2_q = 1;

  logic [23:0] target_q[$];
  angles_t     angles_q[$];
  int          targets_queued = 0;
  int          results_seen = 0;
  int          errors = 0;
  int          idle_cycles = 0;

  longint atan_step_tab [32] = '{
    64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
    64'd3576334374997, 64'd1789910608246, 64'd895173710211, 64'd447614170861,
    64'd223810500369, 64'd111905677066, 64'd55952891894, 64'd27976452617,
    64'd13988227142, 64'd6994113675, 64'd3497056851, 64'd1748528427,
    64'd874264214, 64'd437132107, 64'd218566053, 64'd109283027,
    64'd54641513, 64'd27320757, 64'd13660378, 64'd6830189,
    64'd3415095, 64'd1707547, 64'd853774, 64'd426887,
    64'd213443, 64'd106722, 64'd53361, 64'd26680};

  // first-quadrant atan2(v, u) by cordic vectoring, output scale
  function automatic longint atan_first(longint unsigned v, longint unsigned u);
    longint unsigned m;
    longint x, y, z, dx, dy;
    m = (u > v) ? u : v;
    z = 0;
    if (m == 0) return 0;
    while (m >= (64'd1 << 30)) begin u >>= 1; v >>= 1; m >>= 1; end
    while (m < (64'd1 << 29)) begin u <<= 1; v <<= 1; m <<= 1; end
    x = longint'(u);
    y = longint'(v);
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_step_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_step_tab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * PICO) z = 90 * PICO;
    return ((z << 7) + PICO / 2) / PICO;
  endfunction

  function automatic longint unsigned floor_sqrt(logic [127:0] v);
    longint unsigned r, c;
    logic [127:0] sq;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= v) r = c;
    end
    return r;
  endfunction

  // law-of-cosines angle; 0 when |cos| > 1
  function automatic bit cos_angle(longint n, logic [127:0] lim, output longint ang);
    longint unsigned an;
    logic [127:0] sq;
    an = (n < 0) ? -n : n;
    sq = {64'd0, an} * {64'd0, an};
    ang = 0;
    if (sq > lim) return 0;
    ang = atan_first(floor_sqrt(lim - sq), an);
    if (n < 0) ang = HALF - ang;
    return 1;
  endfunction

  function automatic angles_t solve_arm(logic [23:0] beat);
    angles_t r;
    longint x, y, l1, l2, dsq, l1sq, l2sq, a, b, base, ta, ja;
    logic [127:0] lim_a, lim_b;
    tlas_pkg::status_t st;
    bit ok;
    x = longint'(signed'(beat[11:0]));
    y = longint'(signed'(beat[23:12]));
    l1 = longint'(link1_q);
    l2 = longint'(link2_q);
    r.alpha = 16'(-128);
    r.beta = 16'(-128);
    r.gamma = 16'(-128);
    r.ja = '0;
    r.jb = '0;
    st = tlas_pkg::STATUS_OK;
    if (l1 == 0 || l2 == 0) begin
      st = tlas_pkg::STATUS_ZERO_LINK;
    end else if (x == 0 && y == 0) begin
      st = tlas_pkg::STATUS_UNREACH;
    end else begin
      dsq = x * x + y * y;
      l1sq = l1 * l1;
      l2sq = l2 * l2;
      lim_a = 128'(4 * l2sq) * 128'(dsq);
      lim_b = 128'(4 * l1sq) * 128'(dsq);
      ok = cos_angle(l2sq + dsq - l1sq, lim_a, a);
      if (ok) ok = cos_angle(l1sq + dsq - l2sq, lim_b, b);
      if (!ok) begin
        st = tlas_pkg::STATUS_UNREACH;
      end else begin
        base = atan_first((y < 0) ? -y : y, (x < 0) ? -x : x);
        if (x < 0) base = HALF - base;
        if (y < 0) base = -base;
        ta = HALF - a - b;
        ja = a - base;
        r.alpha = a[15:0];
        r.beta = b[15:0];
        r.gamma = ta[15:0];
        r.ja = ja[16:0];
        r.jb = 15'(HALF - b);
      end
    end
    r.status = st;
    return r;
  endfunction

  // driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        angles_q.push_back(solve_arm(in_tdata));
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (target_q.size() > 0) begin
          in_tdata <= target_q.pop_front();
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      in_tvalid <= offer;
    end
  end

  // monitor: receiver stall pattern, one long hold, result check
  int rx_cycle = 0, hold_left = 0, stall_mode = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    angles_t got, want;
    if (rst_n) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 250 == 0) stall_mode <= $urandom_range(0, 2);
      // long hold while the sender still has plenty to offer
      if (!hold_done && rx_cycle >= 1000 && in_tvalid && target_q.size() > 80) begin
        hold_done <= 1'b1;
        hold_left <= 500;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        got = {out_tdata, out_tuser};
        if (angles_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = angles_q.pop_front();
          if (got.alpha !== want.alpha) begin
            $error("tri_alpha: expected %0d, got %0d", $signed(want.alpha), $signed(got.alpha));
            errors++;
          end
          if (got.beta !== want.beta) begin
            $error("tri_beta: expected %0d, got %0d", $signed(want.beta), $signed(got.beta));
            errors++;
          end
          if (got.gamma !== want.gamma) begin
            $error("tri_gamma: expected %0d, got %0d", $signed(want.gamma), $signed(got.gamma));
            errors++;
          end
          if (got.ja !== want.ja) begin
            $error("joint_a: expected %0d, got %0d", $signed(want.ja), $signed(got.ja));
            errors++;
          end
          if (got.jb !== want.jb) begin
            $error("joint_b: expected %0d, got %0d", want.jb, got.jb);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic queue_target(int x, int y);
    target_q.push_back({12'(y), 12'(x)});
    targets_queued++;
  endtask

  task automatic write_link(tlas_pkg::cfg_reg_t idx, int unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 12'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == tlas_pkg::REG_LINK1) link1_q = val;
    else link2_q = val;
  endtask

  // wait for every result, then let the pipeline settle
  task automatic drain();
    wait (results_seen == targets_queued && target_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_links(int unsigned l1, int unsigned l2);
    drain();
    write_link(tlas_pkg::REG_LINK1, l1);
    write_link(tlas_pkg::REG_LINK2, l2);
  endtask

  // mostly reachable points from random joint angles, some raw noise
  task automatic random_targets(int count);
    real t, p, fx, fy;
    int x, y;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 8) begin
        t = $urandom_range(0, 359999) * 3.14159265358979 / 180000.0;
        p = $urandom_range(0, 359999) * 3.14159265358979 / 180000.0;
        fx = link1_q * $cos(t) + link2_q * $cos(t + p);
        fy = link1_q * $sin(t) + link2_q * $sin(t + p);
        x = $rtoi(fx);
        y = $rtoi(fy);
        if (x > 2047) x = 2047;
        if (x < -2048) x = -2048;
        if (y > 2047) y = 2047;
        if (y < -2048) y = -2048;
        queue_target(x, y);
      end else begin
        queue_target($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048);
      end
    end
  endtask

  int unsigned link_set [12][2] = '{
    '{4095, 4095}, '{4095, 1}, '{1, 4095}, '{700, 900}, '{1200, 800}, '{1023, 1024},
    '{2047, 1}, '{300, 300}, '{1500, 600}, '{2, 3}, '{0, 0}, '{0, 0}};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset links of 1: origin, full reach, extremes, negative-x axis
    queue_target(0, 0);
    queue_target(2, 0);
    queue_target(0, -1);
    queue_target(-1, 0);
    queue_target(2047, 2047);
    queue_target(-2048, -2048);
    queue_target(-2048, 0);
    queue_target(1, 1);
    // 3-4-5 arm: folded and stretched edges, beyond reach, quadrants
    set_links(3, 4);
    queue_target(5, 0);
    queue_target(7, 0);
    queue_target(1, 0);
    queue_target(0, 1);
    queue_target(-3, -4);
    queue_target(8, 0);
    queue_target(-4, 3);
    queue_target(2047, -2048);
    // zero link lengths
    set_links(0, 5);
    queue_target(3, 4);
    queue_target(0, 0);
    set_links(5, 0);
    queue_target(3, 4);
    set_links(0, 0);
    queue_target(-5, 2);

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 10) begin
        set_links(link_set[ph][0], link_set[ph][1]);
      end else begin
        set_links($urandom_range(1, 4095), $urandom_range(1, 4095));
      end
      random_targets(145);
    end

    drain();
    if (errors == 0 && angles_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
